FILE: sv/ipd_stream_splitter_dual_fifo_top_assert.svh
// assertion macros for the ipd stream splitter
`ifndef IPD_STREAM_SPLITTER_DUAL_FIFO_TOP_ASSERT_SVH
`define IPD_STREAM_SPLITTER_DUAL_FIFO_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define IPDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IPDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ipds_pkg.sv
// shared types and constants of the ipd stream splitter
package ipds_pkg;

  localparam logic [2:0] REQ_RX       = 3'd0;
  localparam logic [2:0] REQ_RD_RESP  = 3'd1;
  localparam logic [2:0] REQ_RD_FRAME = 3'd2;
  localparam logic [2:0] REQ_CLR_RESP = 3'd3;
  localparam logic [2:0] REQ_RST_ALL  = 3'd4;

  localparam logic [1:0] STS_BYTE = 2'd0;
  localparam logic [1:0] STS_NONE = 2'd1;
  localparam logic [1:0] STS_LONG = 2'd2;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_I    = 8'h49;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;

  typedef enum logic [2:0] {
    OP_PUSH     = 3'd0,
    OP_RD_RESP  = 3'd1,
    OP_RD_FRAME = 3'd2,
    OP_CLR_RESP = 3'd3,
    OP_RST_ALL  = 3'd4
  } op_t;

  // one classified command between front and back
  typedef struct packed {
    op_t             op;
    logic [3:0][7:0] bytes;   // bytes[0] written first
    logic [2:0]      cnt;
    logic            to_data;
    logic [6:0]      len;     // clamped read length
  } q_entry_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
    logic [8:0] resp_lvl;
    logic [8:0] data_lvl;
  } res_t;

endpackage

FILE: sv/ipds_front.sv
// front: prefix matcher and request classifier
module ipds_front #(
  parameter int MAX_BURST = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              q_ready,
  input  logic [2:0]        req_type,
  input  logic [7:0]        rx_byte,
  input  logic [6:0]        max_len,
  output logic              enq,
  output ipds_pkg::q_entry_t enq_data
);

  typedef enum logic [4:0] {
    M_IDLE = 5'b00001,
    M_PLUS = 5'b00010,
    M_GOTI = 5'b00100,
    M_GOTP = 5'b01000,
    M_DATA = 5'b10000
  } mstate_t;

  mstate_t    ms_r, ms_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       has_op;
  logic       acc;
  logic [6:0] n_clamp;
  ipds_pkg::q_entry_t e;

  assign acc = in_valid && q_ready;
  assign n_clamp = (max_len == 7'd0) ? 7'd1 :
                   ((max_len > 7'(MAX_BURST)) ? 7'(MAX_BURST) : max_len);

  always_comb begin
    ms_nxt    = ms_r;
    prev_nxt  = prev_r;
    has_op    = 1'b0;
    e         = '0;
    e.op      = ipds_pkg::OP_PUSH;
    e.len     = n_clamp;
    case (req_type)
      ipds_pkg::REQ_RX: begin
        case (ms_r)
          M_IDLE: begin
            if (rx_byte == ipds_pkg::CH_PLUS) begin
              ms_nxt = M_PLUS;
            end else begin
              has_op = 1'b1; e.cnt = 3'd1; e.bytes[0] = rx_byte;
            end
          end
          M_PLUS: begin
            if (rx_byte == ipds_pkg::CH_I) begin
              ms_nxt = M_GOTI;
            end else begin
              has_op = 1'b1; e.cnt = 3'd2;
              e.bytes[0] = ipds_pkg::CH_PLUS; e.bytes[1] = rx_byte;
              ms_nxt = M_IDLE;
            end
          end
          M_GOTI: begin
            if (rx_byte == ipds_pkg::CH_P) begin
              ms_nxt = M_GOTP;
            end else begin
              has_op = 1'b1; e.cnt = 3'd3;
              e.bytes[0] = ipds_pkg::CH_PLUS; e.bytes[1] = ipds_pkg::CH_I;
              e.bytes[2] = rx_byte;
              ms_nxt = M_IDLE;
            end
          end
          M_GOTP: begin
            has_op = 1'b1; e.cnt = 3'd4;
            e.bytes[0] = ipds_pkg::CH_PLUS; e.bytes[1] = ipds_pkg::CH_I;
            e.bytes[2] = ipds_pkg::CH_P;
            if (rx_byte == ipds_pkg::CH_D) begin
              e.bytes[3] = ipds_pkg::CH_D; e.to_data = 1'b1;
              ms_nxt = M_DATA; prev_nxt = 8'd0;
            end else begin
              e.bytes[3] = rx_byte;
              ms_nxt = M_IDLE;
            end
          end
          M_DATA: begin
            has_op = 1'b1; e.cnt = 3'd1; e.bytes[0] = rx_byte; e.to_data = 1'b1;
            if (prev_r == ipds_pkg::CH_CR && rx_byte == ipds_pkg::CH_LF) begin
              ms_nxt = M_IDLE;
            end
            prev_nxt = rx_byte;
          end
          default: ms_nxt = M_IDLE;
        endcase
      end
      ipds_pkg::REQ_RD_RESP: begin
        has_op = 1'b1; e.op = ipds_pkg::OP_RD_RESP;
      end
      ipds_pkg::REQ_RD_FRAME: begin
        has_op = 1'b1; e.op = ipds_pkg::OP_RD_FRAME;
      end
      ipds_pkg::REQ_CLR_RESP: begin
        has_op = 1'b1; e.op = ipds_pkg::OP_CLR_RESP;
      end
      ipds_pkg::REQ_RST_ALL: begin
        has_op = 1'b1; e.op = ipds_pkg::OP_RST_ALL;
        ms_nxt = M_IDLE; prev_nxt = 8'd0;
      end
      default: has_op = 1'b0;
    endcase
  end

  assign enq      = acc && has_op;
  assign enq_data = e;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r   <= M_IDLE;
      prev_r <= 8'd0;
    end else if (acc) begin
      ms_r   <= ms_nxt;
      prev_r <= prev_nxt;
    end
  end

endmodule

FILE: sv/ipds_queue.sv
// two-entry command queue between front and back
module ipds_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  ipds_pkg::q_entry_t wr_data,
  output logic               not_full,
  input  logic               rd_en,
  output logic               not_empty,
  output ipds_pkg::q_entry_t rd_data
);

  ipds_pkg::q_entry_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign not_full  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_data   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      if (wr_en && !rd_en) cnt_r <= cnt_r + 2'd1;
      else if (rd_en && !wr_en) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

FILE: sv/ipds_back.sv
// back: the two byte fifos, frame scanner and result sequencer
module ipds_back #(
  parameter int RESP_DEPTH = 256,
  parameter int DATA_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ipds_pkg::q_entry_t q_data,
  output logic               q_pop,
  output logic               res_valid,
  input  logic               res_ready,
  output ipds_pkg::res_t     res
);

  localparam int RA = $clog2(RESP_DEPTH);
  localparam int RF = $clog2(RESP_DEPTH + 1);
  localparam int DA = $clog2(DATA_DEPTH);
  localparam int DF = $clog2(DATA_DEPTH + 1);

  typedef enum logic [7:0] {
    B_IDLE  = 8'b00000001,
    B_PUSH  = 8'b00000010,
    B_RADDR = 8'b00000100,
    B_REMIT = 8'b00001000,
    B_SADDR = 8'b00010000,
    B_SCHK  = 8'b00100000,
    B_DROP  = 8'b01000000,
    B_NONE  = 8'b10000000
  } bstate_t;

  logic [7:0] rmem [RESP_DEPTH];
  logic [7:0] dmem [DATA_DEPTH];

  bstate_t st_r;
  ipds_pkg::q_entry_t ent_r;
  logic [RA-1:0] rhead_r, rtail_r;
  logic [RF-1:0] rfill_r;
  logic [DA-1:0] dhead_r, dtail_r, spos_r;
  logic [DF-1:0] dfill_r, si_r;
  logic [1:0]    idx_r;
  logic [6:0]    rem_r;
  logic          sel_data_r, last_r, prev_cr_r;
  logic [7:0]    rrd_r, drd_r;
  logic          ov_r;
  ipds_pkg::res_t o_r;

  logic          osp;
  logic [7:0]    pbyte;
  logic          rwr, dwr;
  logic [DA-1:0] daddr;
  logic [31:0]   rf32, df32, tail_sum, flen32;
  logic          found;

  assign osp   = !ov_r || res_ready;
  assign q_pop = (st_r == B_IDLE) && q_valid;
  assign pbyte = ent_r.bytes[idx_r];
  assign rwr   = (st_r == B_PUSH) && !ent_r.to_data && (32'(rfill_r) < 32'(RESP_DEPTH));
  assign dwr   = (st_r == B_PUSH) && ent_r.to_data && (32'(dfill_r) < 32'(DATA_DEPTH));
  assign daddr = (st_r == B_SADDR) ? spos_r : dtail_r;
  assign rf32  = 32'(rfill_r);
  assign df32  = 32'(dfill_r);
  assign found = prev_cr_r && (drd_r == ipds_pkg::CH_LF);
  assign flen32   = 32'(si_r) + 32'd1;
  assign tail_sum = 32'(dtail_r) + flen32;

  always_ff @(posedge clk) begin
    if (rwr) rmem[rhead_r] <= pbyte;
    if (dwr) dmem[dhead_r] <= pbyte;
    if (st_r == B_RADDR) rrd_r <= rmem[rtail_r];
    if ((st_r == B_RADDR && sel_data_r) || st_r == B_SADDR) drd_r <= dmem[daddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= B_IDLE;
      rhead_r    <= '0; rtail_r <= '0; rfill_r <= '0;
      dhead_r    <= '0; dtail_r <= '0; dfill_r <= '0;
      ov_r       <= 1'b0;
      idx_r      <= '0;
      rem_r      <= '0;
      sel_data_r <= 1'b0;
      last_r     <= 1'b0;
      prev_cr_r  <= 1'b0;
      si_r       <= '0;
      spos_r     <= '0;
      ent_r      <= '0;
    end else begin
      if (ov_r && res_ready) ov_r <= 1'b0;
      case (st_r)
        B_IDLE: begin
          if (q_valid) begin
            ent_r <= q_data;
            case (q_data.op)
              ipds_pkg::OP_PUSH: begin
                idx_r <= '0;
                st_r  <= B_PUSH;
              end
              ipds_pkg::OP_RD_RESP: begin
                if (rfill_r == '0) begin
                  st_r <= B_NONE;
                end else begin
                  rem_r <= (32'(q_data.len) < rf32) ? q_data.len : 7'(rfill_r);
                  sel_data_r <= 1'b0;
                  st_r <= B_RADDR;
                end
              end
              ipds_pkg::OP_RD_FRAME: begin
                si_r      <= '0;
                spos_r    <= dtail_r;
                prev_cr_r <= 1'b0;
                st_r      <= B_SADDR;
              end
              ipds_pkg::OP_CLR_RESP: begin
                rhead_r <= '0; rtail_r <= '0; rfill_r <= '0;
              end
              ipds_pkg::OP_RST_ALL: begin
                rhead_r <= '0; rtail_r <= '0; rfill_r <= '0;
                dhead_r <= '0; dtail_r <= '0; dfill_r <= '0;
              end
              default: st_r <= B_IDLE;
            endcase
          end
        end
        B_PUSH: begin
          if (rwr) begin
            rhead_r <= (rhead_r == RA'(RESP_DEPTH - 1)) ? '0 : rhead_r + 1'b1;
            rfill_r <= rfill_r + 1'b1;
          end
          if (dwr) begin
            dhead_r <= (dhead_r == DA'(DATA_DEPTH - 1)) ? '0 : dhead_r + 1'b1;
            dfill_r <= dfill_r + 1'b1;
          end
          idx_r <= idx_r + 2'd1;
          if ({1'b0, idx_r} == ent_r.cnt - 3'd1) st_r <= B_IDLE;
        end
        B_RADDR: begin
          if (sel_data_r) begin
            dtail_r <= (dtail_r == DA'(DATA_DEPTH - 1)) ? '0 : dtail_r + 1'b1;
            dfill_r <= dfill_r - 1'b1;
          end else begin
            rtail_r <= (rtail_r == RA'(RESP_DEPTH - 1)) ? '0 : rtail_r + 1'b1;
            rfill_r <= rfill_r - 1'b1;
          end
          last_r <= (rem_r == 7'd1);
          rem_r  <= rem_r - 7'd1;
          st_r   <= B_REMIT;
        end
        B_REMIT: begin
          if (osp) begin
            ov_r         <= 1'b1;
            o_r.out_byte <= sel_data_r ? drd_r : rrd_r;
            o_r.last     <= last_r;
            o_r.status   <= ipds_pkg::STS_BYTE;
            o_r.resp_lvl <= rf32[8:0];
            o_r.data_lvl <= df32[8:0];
            st_r         <= last_r ? B_IDLE : B_RADDR;
          end
        end
        B_SADDR: begin
          st_r <= (si_r == dfill_r) ? B_NONE : B_SCHK;
        end
        B_SCHK: begin
          if (found) begin
            if (flen32 > 32'(ent_r.len)) begin
              dtail_r <= (tail_sum >= 32'(DATA_DEPTH)) ? DA'(tail_sum - 32'(DATA_DEPTH))
                                                      : DA'(tail_sum);
              dfill_r <= DF'(df32 - flen32);
              st_r    <= B_DROP;
            end else begin
              rem_r      <= 7'(flen32);
              sel_data_r <= 1'b1;
              st_r       <= B_RADDR;
            end
          end else begin
            prev_cr_r <= (drd_r == ipds_pkg::CH_CR);
            si_r      <= si_r + 1'b1;
            spos_r    <= (spos_r == DA'(DATA_DEPTH - 1)) ? '0 : spos_r + 1'b1;
            st_r      <= B_SADDR;
          end
        end
        B_DROP, B_NONE: begin
          if (osp) begin
            ov_r         <= 1'b1;
            o_r.out_byte <= 8'd0;
            o_r.last     <= 1'b1;
            o_r.status   <= (st_r == B_DROP) ? ipds_pkg::STS_LONG : ipds_pkg::STS_NONE;
            o_r.resp_lvl <= rf32[8:0];
            o_r.data_lvl <= df32[8:0];
            st_r         <= B_IDLE;
          end
        end
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign res_valid = ov_r;
  assign res       = o_r;

endmodule

FILE: sv/ipd_stream_splitter_dual_fifo_top.sv
// top level of the ipd stream splitter with response and data fifos
// order: an item is queued at its accepting edge and taken from the queue by the back once it is idle;
//   a response read then steps through B_RADDR and B_REMIT before its first byte is shown
// sequence: the back takes each command in B_IDLE, then makes a B_PUSH step per byte pushed (1 to 4),
//   B_RADDR and B_REMIT per byte returned, and B_SADDR and B_SCHK per data fifo byte scanned to cr lf
// reset: synchronous active-low rst_n empties both fifos and idles the matcher
module ipd_stream_splitter_dual_fifo_top #(
  parameter int RESP_DEPTH = 256,
  parameter int DATA_DEPTH = 256,
  parameter int MAX_BURST  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // rx_byte[7:0], max_len[14:8], zero pad
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], resp_level[16:8], data_level[25:17], pad
  output logic [1:0]  out_tuser,  // status[1:0]
  output logic        out_tlast   // last
);

  // front to queue
  logic               enq;
  ipds_pkg::q_entry_t enq_data;
  logic               q_not_full;
  // queue to back
  logic               q_pop;
  logic               q_not_empty;
  ipds_pkg::q_entry_t q_data;
  // back result register
  ipds_pkg::res_t     res;

  assign in_tready = q_not_full;

  ipds_front #(.MAX_BURST(MAX_BURST)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .q_ready  (q_not_full),
    .req_type (in_tuser),
    .rx_byte  (in_tdata[7:0]),
    .max_len  (in_tdata[14:8]),
    .enq      (enq),
    .enq_data (enq_data)
  );

  ipds_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (enq),
    .wr_data   (enq_data),
    .not_full  (q_not_full),
    .rd_en     (q_pop),
    .not_empty (q_not_empty),
    .rd_data   (q_data)
  );

  ipds_back #(.RESP_DEPTH(RESP_DEPTH), .DATA_DEPTH(DATA_DEPTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  // pack the result item onto the stream
  assign out_tdata = {6'd0, res.data_lvl, res.resp_lvl, res.out_byte};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

`include "ipd_stream_splitter_dual_fifo_top_assert.svh"

  // any non-data status closes its request
  `IPDS_ASSERT_NOW(a_status_last, out_tvalid && (res.status != ipds_pkg::STS_BYTE), res.last, "status result without last")
  // non-data results carry a zero byte
  `IPDS_ASSERT_NOW(a_status_zero, out_tvalid && (res.status != ipds_pkg::STS_BYTE), res.out_byte == 8'd0, "status result with data byte")
  // a pop never happens on an empty queue
  `IPDS_ASSERT_NOW(a_pop_nonempty, q_pop, q_not_empty, "command popped from empty queue")
  // an enqueue only happens with room in the queue
  `IPDS_ASSERT_NOW(a_full_block, enq, q_not_full, "enqueue into full queue")
  // a stalled result item stays put
  `IPDS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result item changed while stalled")

endmodule

FILE: tb/sv/ipds_checker.sv
// checker for the ipd stream splitter: predicts results and compares them
module ipds_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          mismatches,
  output int          pending,
  output int          results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 256;
  localparam int BURST = 64;
  localparam logic [2:0] M_IDLE = 3'd0, M_PLUS = 3'd1, M_GOT_I = 3'd2, M_GOT_P = 3'd3,
                         M_DATA = 3'd4;

  logic [7:0] rq_mem [DEPTH];
  int         rq_wr, rq_rd, rq_cnt;
  logic [7:0] dq_mem [DEPTH];
  int         dq_wr, dq_rd, dq_cnt;
  logic [2:0] matcher;
  logic [7:0] last_data_byte;
  ipds_pkg::res_t expected_q [$];

  initial mismatches = 0;
  initial results_seen = 0;
  assign pending = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("[%0t] %s: got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic resp_put(input logic [7:0] b);
    if (rq_cnt < DEPTH) begin
      rq_mem[rq_wr] = b;
      rq_wr = (rq_wr + 1) % DEPTH;
      rq_cnt++;
    end
  endtask

  task automatic data_put(input logic [7:0] b);
    if (dq_cnt < DEPTH) begin
      dq_mem[dq_wr] = b;
      dq_wr = (dq_wr + 1) % DEPTH;
      dq_cnt++;
    end
  endtask

  task automatic queue_result(input logic [7:0] b, input logic lst, input logic [1:0] sts);
    ipds_pkg::res_t r;
    r.out_byte = b;
    r.last     = lst;
    r.status   = sts;
    r.resp_lvl = rq_cnt[8:0];
    r.data_lvl = dq_cnt[8:0];
    expected_q.push_back(r);
  endtask

  // prefix matcher for one received byte
  task automatic take_byte(input logic [7:0] b);
    case (matcher)
      M_IDLE: begin
        if (b == ipds_pkg::CH_PLUS) matcher = M_PLUS;
        else resp_put(b);
      end
      M_PLUS: begin
        if (b == ipds_pkg::CH_I) matcher = M_GOT_I;
        else begin
          resp_put(ipds_pkg::CH_PLUS); resp_put(b); matcher = M_IDLE;
        end
      end
      M_GOT_I: begin
        if (b == ipds_pkg::CH_P) matcher = M_GOT_P;
        else begin
          resp_put(ipds_pkg::CH_PLUS); resp_put(ipds_pkg::CH_I); resp_put(b);
          matcher = M_IDLE;
        end
      end
      M_GOT_P: begin
        if (b == ipds_pkg::CH_D) begin
          data_put(ipds_pkg::CH_PLUS); data_put(ipds_pkg::CH_I);
          data_put(ipds_pkg::CH_P); data_put(ipds_pkg::CH_D);
          matcher = M_DATA;
          last_data_byte = '0;
        end else begin
          resp_put(ipds_pkg::CH_PLUS); resp_put(ipds_pkg::CH_I);
          resp_put(ipds_pkg::CH_P); resp_put(b);
          matcher = M_IDLE;
        end
      end
      M_DATA: begin
        data_put(b);
        if (last_data_byte == ipds_pkg::CH_CR && b == ipds_pkg::CH_LF) matcher = M_IDLE;
        last_data_byte = b;
      end
      default: matcher = M_IDLE;
    endcase
  endtask

  task automatic drain_resp(input int n);
    int k;
    k = 0;
    if (rq_cnt == 0) begin
      queue_result('0, 1'b1, ipds_pkg::STS_NONE);
      return;
    end
    while (k < n && rq_cnt > 0) begin
      logic [7:0] b;
      b = rq_mem[rq_rd];
      rq_rd = (rq_rd + 1) % DEPTH;
      rq_cnt--;
      queue_result(b, (k + 1 == n) || (rq_cnt == 0), ipds_pkg::STS_BYTE);
      k++;
    end
  endtask

  task automatic pull_frame(input int n);
    int flen;
    flen = 0;
    for (int i = 0; i + 1 < dq_cnt; i++) begin
      if (dq_mem[(dq_rd + i) % DEPTH] == ipds_pkg::CH_CR &&
          dq_mem[(dq_rd + i + 1) % DEPTH] == ipds_pkg::CH_LF) begin
        flen = i + 2;
        break;
      end
    end
    if (flen == 0) begin
      queue_result('0, 1'b1, ipds_pkg::STS_NONE);
    end else if (flen > n) begin
      dq_rd = (dq_rd + flen) % DEPTH;
      dq_cnt -= flen;
      queue_result('0, 1'b1, ipds_pkg::STS_LONG);
    end else begin
      for (int i = 0; i < flen; i++) begin
        logic [7:0] b;
        b = dq_mem[dq_rd];
        dq_rd = (dq_rd + 1) % DEPTH;
        dq_cnt--;
        queue_result(b, i + 1 == flen, ipds_pkg::STS_BYTE);
      end
    end
  endtask

  task automatic predict(input logic [2:0] req, input logic [7:0] b, input logic [6:0] ml);
    int n;
    n = (ml < 1) ? 1 : (ml > BURST) ? BURST : int'(ml);
    case (req)
      ipds_pkg::REQ_RX:       take_byte(b);
      ipds_pkg::REQ_RD_RESP:  drain_resp(n);
      ipds_pkg::REQ_RD_FRAME: pull_frame(n);
      ipds_pkg::REQ_CLR_RESP: begin
        rq_wr = 0; rq_rd = 0; rq_cnt = 0;
      end
      ipds_pkg::REQ_RST_ALL: begin
        rq_wr = 0; rq_rd = 0; rq_cnt = 0;
        dq_wr = 0; dq_rd = 0; dq_cnt = 0;
        matcher = M_IDLE;
        last_data_byte = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rq_wr <= 0; rq_rd <= 0; rq_cnt <= 0;
      dq_wr <= 0; dq_rd <= 0; dq_cnt <= 0;
      matcher <= M_IDLE;
      last_data_byte <= '0;
      expected_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("result with nothing expected", out_tdata, 0);
        end else begin
          ipds_pkg::res_t e;
          e = expected_q.pop_front();
          if (out_tdata[7:0] != e.out_byte) report("out_byte", out_tdata[7:0], e.out_byte);
          if (out_tlast != e.last) report("last", out_tlast, e.last);
          if (out_tuser != e.status) report("status", out_tuser, e.status);
          if (out_tdata[16:8] != e.resp_lvl) report("resp_level", out_tdata[16:8], e.resp_lvl);
          if (out_tdata[25:17] != e.data_lvl)
            report("data_level", out_tdata[25:17], e.data_lvl);
        end
      end
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata[7:0], in_tdata[14:8]);
    end
  end
endmodule

FILE: tb/sv/testbench.sv
// stimulus and verdict for the ipd stream splitter
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int          mismatches, pending, results_seen;

  // idling: percentage of cycles the sender idles and the receiver stalls
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;       // long receiver back-pressure stretch
  int          items_sent;
  longint      cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  ipd_stream_splitter_dual_fifo_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  ipds_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  // receiver: random stalls, or fully held off during the pressure stretch
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on total run length
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  // offer one item, wait for acceptance, optional idle gap afterwards
  task automatic send_item(input logic [2:0] req, input logic [7:0] b, input logic [6:0] ml);
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, ml, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tuser  <= 3'($urandom);
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  task automatic send_rx(input logic [7:0] b);
    send_item(ipds_pkg::REQ_RX, b, 7'($urandom));
  endtask

  // well-formed data frame with random payload, ends in cr lf
  task automatic send_frame(input int body);
    send_rx(ipds_pkg::CH_PLUS); send_rx(ipds_pkg::CH_I);
    send_rx(ipds_pkg::CH_P); send_rx(ipds_pkg::CH_D);
    for (int i = 0; i < body; i++) begin
      logic [7:0] b;
      b = 8'($urandom);
      if (b == ipds_pkg::CH_CR) b = 8'h00;
      send_rx(b);
    end
    send_rx(ipds_pkg::CH_CR); send_rx(ipds_pkg::CH_LF);
  endtask

  // random mix: frames, plain text, broken prefixes, reads, rare clears, resets and unknown requests
  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 20) send_frame($urandom_range(0, 6));
    else if (pick < 40) send_rx(8'($urandom));
    else if (pick < 50) begin
      // broken prefix of random depth
      int d;
      d = $urandom_range(1, 3);
      send_rx(ipds_pkg::CH_PLUS);
      if (d > 1) send_rx(ipds_pkg::CH_I);
      if (d > 2) send_rx(ipds_pkg::CH_P);
      send_rx($urandom_range(1) ? ipds_pkg::CH_PLUS : 8'($urandom));
    end
    else if (pick < 70) send_item(ipds_pkg::REQ_RD_RESP, 8'($urandom),
                                  7'($urandom_range(0, 127)));
    else if (pick < 92) send_item(ipds_pkg::REQ_RD_FRAME, 8'($urandom),
                                  $urandom_range(3) == 0 ? 7'($urandom) :
                                                           7'($urandom_range(4, 20)));
    else if (pick < 95) send_item(ipds_pkg::REQ_CLR_RESP, 8'($urandom), 7'($urandom));
    else if (pick < 97) send_item(ipds_pkg::REQ_RST_ALL, 8'($urandom), 7'($urandom));
    else send_item(3'($urandom_range(5, 7)), 8'($urandom), 7'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b0;
    items_sent     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ipds_pkg::REQ_RX;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, text, every prefix break, frames short and too long
    send_item(ipds_pkg::REQ_RD_RESP, 8'h00, 7'd0);
    send_item(ipds_pkg::REQ_RD_FRAME, 8'hFF, 7'd127);
    send_rx(8'h00); send_rx(8'hFF);
    send_rx(ipds_pkg::CH_PLUS); send_rx(ipds_pkg::CH_PLUS);
    send_rx(ipds_pkg::CH_PLUS); send_rx(ipds_pkg::CH_I); send_rx(8'h55);
    send_rx(ipds_pkg::CH_PLUS); send_rx(ipds_pkg::CH_I); send_rx(ipds_pkg::CH_P);
    send_rx(8'hAA);
    send_item(ipds_pkg::REQ_RD_RESP, 8'h00, 7'd64);
    send_frame(2);
    send_item(ipds_pkg::REQ_RD_FRAME, 8'h00, 7'd2);
    send_frame(1);
    send_item(ipds_pkg::REQ_RD_FRAME, 8'h00, 7'd64);
    send_rx(8'h7E);
    send_item(ipds_pkg::REQ_CLR_RESP, 8'h00, 7'd1);
    send_item(ipds_pkg::REQ_RD_RESP, 8'h00, 7'd1);
    send_item(3'd6, 8'h00, 7'd1);
    send_item(ipds_pkg::REQ_RST_ALL, 8'h00, 7'd1);
    wait_drained();

    // fill the response fifo past its depth so writes are dropped
    for (int i = 0; i < 262; i++) send_item(ipds_pkg::REQ_RX, 8'(i), 7'd0);
    for (int i = 0; i < 5; i++) send_item(ipds_pkg::REQ_RD_RESP, 8'h00, 7'd100);
    send_item(ipds_pkg::REQ_RST_ALL, 8'h00, 7'd0);
    wait_drained();

    // random phases with different idling
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 82 : 17) : 0;
      recv_stall_pct = (ph == 2) ? 82 : (ph == 3 ? 17 : 0);
      for (int i = 0; i < 6; i++) random_item();
      wait_drained();
    end

    // pressure: receiver holds off while long reads keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 10; i++) send_rx(8'($urandom));
    fork
      begin
        hold_off = 1'b1;
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 5; i++) begin
          send_item(ipds_pkg::REQ_RD_RESP, 8'h00, 7'd64);
          send_rx(8'($urandom));
        end
      end
    join
    in_tvalid <= 1'b0;
    wait_drained();

    $display("sent %0d items, checked %0d results across four idling phases", items_sent,
             results_seen);
    $display("covered prefix breaks, frames, overlong frames, full fifo and back-pressure");
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

FILE: sim.f
+incdir+sv
sv/ipds_pkg.sv
sv/ipds_front.sv
sv/ipds_queue.sv
sv/ipds_back.sv
sv/ipd_stream_splitter_dual_fifo_top.sv
tb/sv/ipds_checker.sv
tb/sv/testbench.sv
